// ----- hw/rtl/piecewise_linear_interp_table_defines.svh -----
// Assertion macros shared by the interpolation table modules.
`ifndef PIECEWISE_LINEAR_INTERP_TABLE_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERP_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/pli_pkg.sv -----
package pli_pkg;

	localparam int DATA_W    = 32;
	localparam int DEPTH_DEF = 16;
	localparam int DIV_STEPS = DATA_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic FUNC_ADD = 1'b0;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_VALUE,
		RES_LERP
	} res_sel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_MAG,
		S_MUL,
		S_DIV,
		S_FIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic     in_load;
		logic     ram_we;
		logic     prev_load;
		logic     diff_load;
		logic     mag_load;
		logic     mul_load;
		logic     div_step;
		logic     res_load;
		res_sel_t res_sel;
		logic     out_load;
		status_t  status;
	} dp_cmd_t;

	typedef struct packed {
		logic func;
		logic x_gt_key;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- hw/rtl/pli_ram.sv -----
module pli_ram
	import pli_pkg::*;
#(
	parameter int WIDTH = 2 * DATA_W,
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/pli_ctrl.sv -----
`include "piecewise_linear_interp_table_defines.svh"

module pli_ctrl
	import pli_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int IDX_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  dp_stat_t         stat,
	output dp_cmd_t          cmd,
	output logic [IDX_W-1:0] rd_addr,
	output logic [IDX_W-1:0] wr_addr
);

	state_t                 state_q, state_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic [IDX_W-1:0]       idx_q, idx_d;
	logic [DIV_CNT_W-1:0]   div_cnt_q, div_cnt_d;
	status_t                status_q, status_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q     <= idx_d;
		div_cnt_q <= div_cnt_d;
		status_q  <= status_d;
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		idx_d       = idx_q;
		div_cnt_d   = div_cnt_q;
		status_d    = status_q;
		cmd         = '0;
		cmd.res_sel = RES_ZERO;
		cmd.status  = status_q;
		rd_addr     = '0;
		wr_addr     = cnt_q[IDX_W-1:0];
		in_stall    = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.in_load = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.func == FUNC_ADD) begin
					if (cnt_q < CNT_W'(DEPTH)) begin
						cmd.ram_we = 1'b1;
						cnt_d      = cnt_q + CNT_W'(1);
						status_d   = ST_OK;
					end else begin
						status_d = ST_FULL;
					end
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_ZERO;
					state_d      = S_OUT;
				end else if (cnt_q == '0) begin
					status_d     = ST_EMPTY;
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_ZERO;
					state_d      = S_OUT;
				end else begin
					status_d = ST_OK;
					idx_d    = '0;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!stat.x_gt_key) begin
					rd_addr = idx_q;
					if (idx_q == '0) begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = RES_VALUE;
						state_d      = S_OUT;
					end else begin
						cmd.diff_load = 1'b1;
						state_d       = S_MAG;
					end
				end else begin
					rd_addr       = idx_q + IDX_W'(1);
					cmd.prev_load = 1'b1;
					if (CNT_W'(idx_q) + CNT_W'(1) == cnt_q) begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = RES_VALUE;
						state_d      = S_OUT;
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
			end
			S_MAG: begin
				cmd.mag_load = 1'b1;
				state_d      = S_MUL;
			end
			S_MUL: begin
				cmd.mul_load = 1'b1;
				div_cnt_d    = '0;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				div_cnt_d    = div_cnt_q + DIV_CNT_W'(1);
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = RES_LERP;
				state_d      = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`PLI_ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CNT_W'(DEPTH), "entry count above depth")
	`PLI_ASSERT_IMPL(a_scan_idx, clk, arst_n, state_q == S_SCAN, CNT_W'(idx_q) < cnt_q, "scan past stored entries")
	`PLI_ASSERT_IMPL(a_write_room, clk, arst_n, cmd.ram_we, cnt_q < CNT_W'(DEPTH), "write into a full table")

endmodule

// ----- hw/rtl/pli_dp.sv -----
`include "piecewise_linear_interp_table_defines.svh"

module pli_dp
	import pli_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              func,
	input  logic [DATA_W-1:0] key,
	input  logic [DATA_W-1:0] value,
	input  dp_cmd_t           cmd,
	input  logic [IDX_W-1:0]  rd_addr,
	input  logic [IDX_W-1:0]  wr_addr,
	output dp_stat_t          stat,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] result,
	output logic [1:0]        status
);

	localparam int PW = 2 * DATA_W;

	function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W:0] d);
		logic [DATA_W:0] n;
		n = d[DATA_W] ? (~d + (DATA_W + 1)'(1)) : d;
		return n[DATA_W-1:0];
	endfunction

	logic                func_q;
	logic [DATA_W-1:0]   x_q, val_q;
	logic [DATA_W-1:0]   prev_k_q, prev_v_q, v1_q;
	logic [DATA_W:0]     dv_q, dx_q, dk_q;
	logic [DATA_W-1:0]   mv_q, mx_q, mk_q;
	logic                neg_q;
	logic [DATA_W-1:0]   rem_q, quo_q;
	logic [DATA_W-1:0]   res_q;
	logic                out_valid_q;
	logic [DATA_W-1:0]   result_q;
	status_t             status_q;

	logic [PW-1:0]       rd_data;
	logic [DATA_W-1:0]   rd_key, rd_val;
	logic [PW-1:0]       prod;
	logic [DATA_W:0]     div_tmp, div_sub;
	logic                div_ge;
	logic [DATA_W+1:0]   v1_ext, q_ext, y_sum;
	logic [DATA_W-1:0]   y_sat;
	logic [DATA_W-1:0]   res_d;

	pli_ram #(
		.WIDTH (PW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (cmd.ram_we),
		.wr_addr (wr_addr),
		.wr_data ({x_q, val_q}),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_key = rd_data[PW-1:DATA_W];
	assign rd_val = rd_data[DATA_W-1:0];

	assign prod = PW'(mv_q) * PW'(mx_q);

	assign div_tmp = {rem_q, quo_q[DATA_W-1]};
	assign div_sub = div_tmp - {1'b0, mk_q};
	assign div_ge  = div_tmp >= {1'b0, mk_q};

	assign v1_ext = {{2{v1_q[DATA_W-1]}}, v1_q};
	assign q_ext  = {2'b00, quo_q};
	assign y_sum  = neg_q ? (v1_ext - q_ext) : (v1_ext + q_ext);

	always_comb begin
		if (y_sum[DATA_W+1:DATA_W-1] == 3'b000 || y_sum[DATA_W+1:DATA_W-1] == 3'b111) begin
			y_sat = y_sum[DATA_W-1:0];
		end else if (y_sum[DATA_W+1]) begin
			y_sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	always_comb begin
		case (cmd.res_sel)
			RES_ZERO:  res_d = '0;
			RES_VALUE: res_d = rd_val;
			RES_LERP:  res_d = y_sat;
			default:   res_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			func_q <= func;
			x_q    <= key;
			val_q  <= value;
		end
		if (cmd.prev_load) begin
			prev_k_q <= rd_key;
			prev_v_q <= rd_val;
		end
		if (cmd.diff_load) begin
			dv_q <= {prev_v_q[DATA_W-1], prev_v_q} - {rd_val[DATA_W-1], rd_val};
			dx_q <= {x_q[DATA_W-1], x_q} - {rd_key[DATA_W-1], rd_key};
			dk_q <= {prev_k_q[DATA_W-1], prev_k_q} - {rd_key[DATA_W-1], rd_key};
			v1_q <= rd_val;
		end
		if (cmd.mag_load) begin
			mv_q  <= mag_of(dv_q);
			mx_q  <= mag_of(dx_q);
			mk_q  <= mag_of(dk_q);
			neg_q <= dv_q[DATA_W] ^ dx_q[DATA_W] ^ dk_q[DATA_W];
		end
		if (cmd.mul_load) begin
			rem_q <= prod[PW-1:DATA_W];
			quo_q <= prod[DATA_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? div_sub[DATA_W-1:0] : div_tmp[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], div_ge};
		end
		if (cmd.res_load) begin
			res_q <= res_d;
		end
		if (cmd.out_load) begin
			result_q <= res_q;
			status_q <= cmd.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.func     = func_q;
	assign stat.x_gt_key = $signed(x_q) > $signed(rd_key);
	assign stat.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign status    = status_q;

	`PLI_ASSERT_IMPL(a_out_no_overwrite, clk, arst_n, cmd.out_load, !out_valid_q || !out_stall, "result overwritten while stalled")
	`PLI_ASSERT_NEXT(a_div_nonzero, clk, arst_n, cmd.mag_load, mk_q != '0, "zero divisor for interpolation")
	`PLI_ASSERT_IMPL(a_div_rem_bound, clk, arst_n, cmd.div_step, rem_q < mk_q, "division remainder not below divisor")

endmodule

// ----- hw/rtl/piecewise_linear_interp_table.sv -----
// Breakpoint table with linear interpolation in signed Q16.16.
// Requests arrive on in_valid/in_stall with func, key and value. With func low a request
// appends the breakpoint (key, value); when the table is full it is dropped with status 1.
// With func high the request interpolates at key; an empty table answers 0 with status 2.
// Every request gives exactly one response on out_valid/out_stall with result and status.
// The block works on one request at a time and raises in_stall while it is busy.
// An append passes through decode and output states and the block then returns to idle.
// A query scans the stored keys one per cycle through the single read port of the table
// memory. A query at or below the first key stops the scan there, and one above the last
// key stops after all stored keys; both answer a stored value without interpolating.
// An interpolating query adds one 32 by 32 multiply and a 32-step restoring divide.
// The response sits in an output register, so the next request is taken while it waits.
// If out_stall is high the response holds; a new response waits until the register frees.
// Reset empties the table and clears the pending response; stored entries are not cleared.
module piecewise_linear_interp_table
	import pli_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              func,
	input  logic [DATA_W-1:0] key,
	input  logic [DATA_W-1:0] value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] result,
	output logic [1:0]        status
);

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;

	pli_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr)
	);

	pli_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.func      (func),
		.key       (key),
		.value     (value),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result),
		.status    (status)
	);

endmodule
